[rtl/assert_macros.svh]
// assertion helpers used by the grid graph builder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/gge_pkg.sv]
package gge_pkg;

    localparam int NODE_W  = 16;
    localparam int COUNT_W = 9;
    localparam int POS_W   = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // reset value of both count registers
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_COLUMN_COUNT = 1'b0,
        REG_ROW_COUNT    = 1'b1
    } reg_index_t;

    // line buffer entry: valid bit and node number
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
    } entry_t;

    typedef struct packed {
        logic cell_usable;
        logic frame_start;
    } cell_in_t;

    typedef struct packed {
        logic              node_valid;
        logic [NODE_W-1:0] node_number;
        logic [POS_W-1:0]  col_pos;
        logic [POS_W-1:0]  row_pos;
        logic              left_valid;
        logic [NODE_W-1:0] left_node;
        logic              up_valid;
        logic [NODE_W-1:0] up_node;
        logic              upleft_valid;
        logic [NODE_W-1:0] upleft_node;
        logic              upright_valid;
        logic [NODE_W-1:0] upright_node;
    } node_out_t;

endpackage

[rtl/grid_graph_edge_builder.sv]
// Streaming 8-neighbour grid graph builder. One walkability bit per cell is
// taken in raster order on the cell channel; each usable cell gets the next
// dense node number from zero, and every cell yields one result transfer
// with its node number, coordinates and the usable left, up, up-left and
// up-right neighbours. Throughput is one cell per clock while the result
// channel does not stall; a cell moves through stage 1 and the result
// register: a position/counter unit places the cell at accept time and
// issues two reads (column x and x+1) to the line buffer RAM, and a second
// stage forms the neighbours and writes the cell back into the line buffer.
// The line buffer is one RAM with one write and two registered read ports;
// it has no clearing pass, since the first row of a frame never uses it.
// column_count (offset 0) and row_count (offset 4) are 9-bit registers; a
// count of zero acts as one and a count above MAX_COLS / MAX_ROWS acts as
// that maximum. Write them only while no cell is in flight.
`include "assert_macros.svh"

module grid_graph_edge_builder #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // cell channel
    input  logic                         cell_valid,
    output logic                         cell_ready,
    input  gge_pkg::cell_in_t            cell_data,
    // result channel
    output logic                         result_valid,
    input  logic                         result_ready,
    output gge_pkg::node_out_t           result_data,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gge_pkg::APB_AW-1:0]   paddr,
    input  logic [gge_pkg::APB_DW-1:0]   pwdata,
    output logic [gge_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CCMP = (CW + 1 > gge_pkg::COUNT_W) ? CW + 1 : gge_pkg::COUNT_W;
    localparam int RCMP = (RW + 1 > gge_pkg::COUNT_W) ? RW + 1 : gge_pkg::COUNT_W;

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    logic [gge_pkg::COUNT_W-1:0] column_count_reg;
    logic [gge_pkg::COUNT_W-1:0] row_count_reg;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= gge_pkg::COUNT_RESET;
            row_count_reg    <= gge_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                gge_pkg::REG_COLUMN_COUNT: column_count_reg <= pwdata[gge_pkg::COUNT_W-1:0];
                gge_pkg::REG_ROW_COUNT:    row_count_reg    <= pwdata[gge_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            gge_pkg::REG_COLUMN_COUNT: prdata = gge_pkg::APB_DW'(column_count_reg);
            gge_pkg::REG_ROW_COUNT:    prdata = gge_pkg::APB_DW'(row_count_reg);
            default:                   prdata = '0;
        endcase
    end

    // effective counts: zero acts as one, capped at the maximum
    logic [CW:0] ncols;
    logic [RW:0] nrows;

    always_comb
    begin
        if (column_count_reg == '0)
            ncols = (CW + 1)'(1);
        else if (CCMP'(column_count_reg) > CCMP'(MAX_COLS))
            ncols = (CW + 1)'(MAX_COLS);
        else
            ncols = (CW + 1)'(column_count_reg);

        if (row_count_reg == '0)
            nrows = (RW + 1)'(1);
        else if (RCMP'(row_count_reg) > RCMP'(MAX_ROWS))
            nrows = (RW + 1)'(MAX_ROWS);
        else
            nrows = (RW + 1)'(row_count_reg);
    end

    // ---------------------------------------------------------------
    // handshake: stage 1 moves on when the result register frees up
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_advance;
    logic cell_accept;

    assign s1_advance  = s1_valid_reg && (!result_valid || result_ready);
    assign cell_ready  = !s1_valid_reg || s1_advance;
    assign cell_accept = cell_valid && cell_ready;

    // ---------------------------------------------------------------
    // position unit
    // ---------------------------------------------------------------
    logic [CW-1:0]              pos_x;
    logic [RW-1:0]              pos_y;
    logic [gge_pkg::NODE_W-1:0] pos_node;
    logic                       pos_last_col;

    gge_pos #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (cell_accept),
        .cell_usable (cell_data.cell_usable),
        .frame_start (cell_data.frame_start),
        .ncols       (ncols),
        .nrows       (nrows),
        .x           (pos_x),
        .y           (pos_y),
        .node        (pos_node),
        .last_col    (pos_last_col)
    );

    // ---------------------------------------------------------------
    // line buffer
    // ---------------------------------------------------------------
    logic [CW-1:0]   raddr1;
    gge_pkg::entry_t rd_up, rd_upright;
    gge_pkg::entry_t s1_here;
    logic [CW-1:0]   s1_x_reg;

    // wraps at the top address, reached only in the last column, where the up-right read is unused
    assign raddr1 = pos_x + CW'(1);

    gge_ram #(
        .WIDTH ($bits(gge_pkg::entry_t)),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .clk    (clk),
        .we     (s1_advance),
        .waddr  (s1_x_reg),
        .wdata  (s1_here),
        .re     (cell_accept),
        .raddr0 (pos_x),
        .raddr1 (raddr1),
        .rdata0 (rd_up),
        .rdata1 (rd_upright)
    );

    // ---------------------------------------------------------------
    // stage 1: cell placed, line buffer data arriving
    // ---------------------------------------------------------------
    logic                       s1_usable_reg;
    logic [RW-1:0]              s1_y_reg;
    logic [gge_pkg::NODE_W-1:0] s1_node_reg;
    logic                       s1_last_col_reg;
    logic                       s1_fwd_up_reg;
    logic                       s1_fwd_ur_reg;
    gge_pkg::entry_t            s1_fwd_data_reg;

    // previous cell's own entry and its up entry (left / up-left source)
    gge_pkg::entry_t last_here_reg;
    gge_pkg::entry_t last_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cell_ready)
        begin
            s1_valid_reg <= cell_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_accept)
        begin
            s1_usable_reg   <= cell_data.cell_usable;
            s1_x_reg        <= pos_x;
            s1_y_reg        <= pos_y;
            s1_node_reg     <= pos_node;
            s1_last_col_reg <= pos_last_col;
            // read and write of one entry at the same edge: take the new data
            s1_fwd_up_reg   <= s1_advance && (s1_x_reg == pos_x);
            s1_fwd_ur_reg   <= s1_advance && (s1_x_reg == raddr1);
            s1_fwd_data_reg <= s1_here;
        end
    end

    gge_pkg::entry_t    up_entry, upright_entry, left_entry, upleft_entry;
    gge_pkg::node_out_t res;
    logic               s1_row_above;
    logic               s1_col_left;

    always_comb
    begin
        s1_row_above = (s1_y_reg != '0);
        s1_col_left  = (s1_x_reg != '0);

        s1_here.valid = s1_usable_reg;
        s1_here.node  = s1_usable_reg ? s1_node_reg : '0;

        up_entry      = s1_fwd_up_reg ? s1_fwd_data_reg : rd_up;
        upright_entry = s1_fwd_ur_reg ? s1_fwd_data_reg : rd_upright;
        if (!s1_row_above)
            up_entry = '0;
        if (!s1_row_above || s1_last_col_reg)
            upright_entry = '0;
        left_entry   = s1_col_left ? last_here_reg : '0;
        upleft_entry = (s1_col_left && s1_row_above) ? last_up_reg : '0;

        res = '0;
        res.col_pos = gge_pkg::POS_W'(s1_x_reg);
        res.row_pos = gge_pkg::POS_W'(s1_y_reg);
        if (s1_usable_reg)
        begin
            res.node_valid    = 1'b1;
            res.node_number   = s1_node_reg;
            res.left_valid    = left_entry.valid;
            res.left_node     = left_entry.valid ? left_entry.node : '0;
            res.up_valid      = up_entry.valid;
            res.up_node       = up_entry.valid ? up_entry.node : '0;
            res.upleft_valid  = upleft_entry.valid;
            res.upleft_node   = upleft_entry.valid ? upleft_entry.node : '0;
            res.upright_valid = upright_entry.valid;
            res.upright_node  = upright_entry.valid ? upright_entry.node : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_here_reg <= '0;
            last_up_reg   <= '0;
        end
        else if (s1_advance)
        begin
            last_here_reg <= s1_here;
            last_up_reg   <= up_entry;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic               result_valid_reg;
    gge_pkg::node_out_t result_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_data_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a blocked cell carries no edges
    `ASSERT_IMPLY(a_blocked_no_edges, clk, rst_n,
        result_valid && !result_data.node_valid,
        !(result_data.left_valid || result_data.up_valid ||
          result_data.upleft_valid || result_data.upright_valid))

    // a blocked cell carries node number zero
    `ASSERT_IMPLY(a_blocked_node_zero, clk, rst_n,
        result_valid && !result_data.node_valid,
        result_data.node_number == '0)

    // the left neighbour is always the node numbered just before
    `ASSERT_IMPLY(a_left_is_previous, clk, rst_n,
        result_valid && result_data.left_valid,
        result_data.node_valid && (result_data.left_node + 1'b1 == result_data.node_number))

    // a stage 1 transfer always lands in the result register
    `ASSERT_NEXT(a_stage_to_result, clk, rst_n,
        s1_advance,
        result_valid)

endmodule

[rtl/gge_ram.sv]
module gge_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

[rtl/gge_pos.sv]
module gge_pos #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            cell_usable,
    input  logic                            frame_start,
    input  logic [$clog2(MAX_COLS):0]       ncols,
    input  logic [$clog2(MAX_ROWS):0]       nrows,
    output logic [$clog2(MAX_COLS)-1:0]     x,
    output logic [$clog2(MAX_ROWS)-1:0]     y,
    output logic [gge_pkg::NODE_W-1:0]      node,
    output logic                            last_col
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [CW-1:0]              col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;
    logic [gge_pkg::NODE_W-1:0] node_reg, node_next;

    logic [CW-1:0]              c0, c1;
    logic [RW-1:0]              r0;
    logic [RW:0]                r1, rn;
    logic [CW:0]                cx;
    logic [gge_pkg::NODE_W-1:0] n0, n1;

    always_comb
    begin
        // restart on frame flag
        c0 = frame_start ? '0 : col_reg;
        r0 = frame_start ? '0 : row_reg;
        n0 = frame_start ? '0 : node_reg;

        // close row / frame if bounds shrank
        if ({1'b0, c0} >= ncols)
        begin
            c1 = '0;
            r1 = {1'b0, r0} + 1'b1;
        end
        else
        begin
            c1 = c0;
            r1 = {1'b0, r0};
        end
        if (r1 >= nrows)
        begin
            x    = '0;
            y    = '0;
            node = '0;
        end
        else
        begin
            x    = c1;
            y    = r1[RW-1:0];
            node = n0;
        end

        // step past this cell
        cx       = {1'b0, x} + 1'b1;
        last_col = (cx >= ncols);
        n1       = cell_usable ? node + 1'b1 : node;
        if (last_col)
        begin
            col_next = '0;
            rn       = {1'b0, y} + 1'b1;
        end
        else
        begin
            col_next = cx[CW-1:0];
            rn       = {1'b0, y};
        end
        if (rn >= nrows)
        begin
            col_next  = '0;
            row_next  = '0;
            node_next = '0;
        end
        else
        begin
            row_next  = rn[RW-1:0];
            node_next = n1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            node_reg <= '0;
        end
        else if (advance)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            node_reg <= node_next;
        end
    end

endmodule
